// ===== hw/rtl/tasa_pkg.sv =====
package tasa_pkg;

    // default sizes
    localparam int MAX_DIM_DEF     = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ACC_BITS_DEF    = 40;

    // fixed field widths
    localparam int RESULT_BITS    = 40;
    localparam int INDEX_BITS     = 12;
    localparam int DIM_CFG_BITS   = 7;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 7;

    typedef logic [1:0]              axis_mode_t;
    typedef logic [DIM_CFG_BITS-1:0] dim_cfg_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // register indexes
    localparam cfg_index_t CFG_AXIS_MODE    = 3'd0;
    localparam cfg_index_t CFG_MEAN_ENABLE  = 3'd1;
    localparam cfg_index_t CFG_NUM_CHANNELS = 3'd2;
    localparam cfg_index_t CFG_NUM_ROWS     = 3'd3;
    localparam cfg_index_t CFG_NUM_COLS     = 3'd4;

    // reduction axis codes
    localparam axis_mode_t AXIS_ALL  = 2'd0;
    localparam axis_mode_t AXIS_CHAN = 2'd1;
    localparam axis_mode_t AXIS_ROW  = 2'd2;
    localparam axis_mode_t AXIS_COL  = 2'd3;

    localparam dim_cfg_t DIM_RESET = 7'd64;

endpackage

// ===== hw/rtl/tasa_in_if.sv =====
interface tasa_in_if
    import tasa_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

// ===== hw/rtl/tasa_out_if.sv =====
interface tasa_out_if
    import tasa_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic signed [RESULT_BITS-1:0] result_value;
    logic [INDEX_BITS-1:0]         result_index;
    logic                          frame_last;

    modport source (output valid, output result_value, output result_index,
                    output frame_last, input ready);
    modport sink   (input valid, input result_value, input result_index,
                    input frame_last, output ready);
endinterface

// ===== hw/rtl/tasa_ram.sv =====
module tasa_ram
    import tasa_pkg::*;
#(
    parameter int WIDTH = ACC_BITS_DEF,
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/tasa_div.sv =====
module tasa_div
    import tasa_pkg::*;
#(
    parameter int DIVIDEND_BITS = ACC_BITS_DEF,
    parameter int DIVISOR_BITS  = 19
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     done,
    output logic [DIVIDEND_BITS-1:0] quotient
);

    localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIVISOR_BITS:0]    rem_shift;
    logic [DIVISOR_BITS:0]    rem_diff;
    logic                     fits;

    // one restoring step per cycle, most significant bit first
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = rem_shift >= {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            step_next = STEP_BITS'(DIVIDEND_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_BITS-2:0], fits};
            rem_next  = fits ? rem_diff[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
            step_next = step_reg - STEP_BITS'(1);
            if (step_reg == STEP_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/tensor_axis_sum_mean_unit.sv =====
// Sequence: an accepted request goes to the accumulate step, which forms the sum and stores it;
// a request that gives a sum then waits in S_OUT for a free output register, and with mean_enable
// set the divider runs first (S_DIV, one quotient bit a cycle). Input is ready only in S_IDLE, so
// no new sample is taken before the last is through, and a stalled output also holds the input.
// Reset: registers take their register-list values, positions and total sum clear;
// the accumulator memory is not cleared, each entry is overwritten by its first sample.
module tensor_axis_sum_mean_unit
    import tasa_pkg::*;
#(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int ACC_BITS    = ACC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    tasa_in_if.sink                  in_ch,
    tasa_out_if.source               out_ch,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int POS_BITS    = $clog2(MAX_DIM);
    localparam int DIM_BITS    = $clog2(MAX_DIM + 1);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int IDX_BITS    = $clog2(STORE_DEPTH);
    localparam int CNT_BITS    = $clog2(MAX_DIM * MAX_DIM * MAX_DIM + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // zero acts as one, oversize clamps to the maximum
    function automatic logic [DIM_BITS-1:0] eff_dim(input dim_cfg_t v);
        logic [DIM_BITS-1:0] d;
        if (v == '0)
        begin
            d = DIM_BITS'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            d = DIM_BITS'(MAX_DIM);
        end
        else
        begin
            d = DIM_BITS'(v);
        end
        return d;
    endfunction

    logic [1:0]          state_reg, state_next;
    axis_mode_t          axis_mode_reg;
    logic                mean_enable_reg;
    dim_cfg_t            num_channels_reg, num_rows_reg, num_cols_reg;
    logic [POS_BITS-1:0] chan_pos_reg, chan_pos_next;
    logic [POS_BITS-1:0] row_pos_reg, row_pos_next;
    logic [POS_BITS-1:0] col_pos_reg, col_pos_next;
    logic [ACC_BITS-1:0] total_sum_reg, total_sum_next;
    logic [ACC_BITS-1:0] x_reg, x_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                first_reg, first_next;
    logic                emit_reg, emit_next;
    logic                fl_reg, fl_next;
    logic                whole_reg, whole_next;
    logic                neg_reg, neg_next;
    logic [ACC_BITS-1:0] res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    logic [ACC_BITS-1:0] out_value_reg, out_value_next;
    logic [IDX_BITS-1:0] out_index_reg, out_index_next;
    logic                out_last_reg, out_last_next;

    logic [DIM_BITS-1:0] nc_eff, nr_eff, nw_eff;
    logic                c_last, r_last, w_last;
    logic                in_accept;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [IDX_BITS-1:0] rd_addr;
    logic [ACC_BITS-1:0] ram_rdata;
    logic                ram_we;
    logic [ACC_BITS-1:0] sum;
    logic [ACC_BITS-1:0] base;
    logic                div_start;
    logic [ACC_BITS-1:0] div_dividend;
    logic [CNT_BITS-1:0] div_divisor;
    logic                div_done;
    logic [ACC_BITS-1:0] div_quo;

    // effective dimensions and last-position flags
    assign nc_eff    = eff_dim(num_channels_reg);
    assign nr_eff    = eff_dim(num_rows_reg);
    assign nw_eff    = eff_dim(num_cols_reg);
    assign c_last    = DIM_BITS'(chan_pos_reg) >= nc_eff - DIM_BITS'(1);
    assign r_last    = DIM_BITS'(row_pos_reg) >= nr_eff - DIM_BITS'(1);
    assign w_last    = DIM_BITS'(col_pos_reg) >= nw_eff - DIM_BITS'(1);
    assign in_accept = in_ch.valid && in_ch.ready;
    assign sample_in = in_ch.sample_value;

    // accumulator address for the current position
    always_comb
    begin
        unique case (axis_mode_reg)
            AXIS_CHAN: rd_addr = IDX_BITS'(row_pos_reg) * IDX_BITS'(nw_eff)
                                 + IDX_BITS'(col_pos_reg);
            AXIS_ROW:  rd_addr = IDX_BITS'(chan_pos_reg) * IDX_BITS'(nw_eff)
                                 + IDX_BITS'(col_pos_reg);
            AXIS_COL:  rd_addr = IDX_BITS'(chan_pos_reg) * IDX_BITS'(nr_eff)
                                 + IDX_BITS'(row_pos_reg);
            default:   rd_addr = '0;
        endcase
    end

    // accumulate arithmetic
    assign base         = whole_reg ? total_sum_reg : ram_rdata;
    assign sum          = first_reg ? x_reg : base + x_reg;
    assign div_dividend = sum[ACC_BITS-1] ? ACC_BITS'(-sum) : sum;
    assign div_divisor  = whole_reg ? CNT_BITS'(cnt_reg * CNT_BITS'(nw_eff)) : cnt_reg;
    assign div_start    = (state_reg == S_ACC) && emit_reg && mean_enable_reg;
    assign ram_we       = (state_reg == S_ACC) && !whole_reg;

    tasa_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_accum_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (sum),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    tasa_div #(
        .DIVIDEND_BITS (ACC_BITS),
        .DIVISOR_BITS  (CNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // sequencer: accept, read-modify-write, optional divide, hand to output register
    always_comb
    begin
        state_next     = state_reg;
        chan_pos_next  = chan_pos_reg;
        row_pos_next   = row_pos_reg;
        col_pos_next   = col_pos_reg;
        total_sum_next = total_sum_reg;
        x_next         = x_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        emit_next      = emit_reg;
        fl_next        = fl_reg;
        whole_next     = whole_reg;
        neg_next       = neg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_value_next = out_value_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    x_next     = ACC_BITS'(sample_in);
                    idx_next   = rd_addr;
                    whole_next = axis_mode_reg == AXIS_ALL;
                    unique case (axis_mode_reg)
                        AXIS_CHAN:
                        begin
                            first_next = chan_pos_reg == '0;
                            emit_next  = c_last;
                            fl_next    = r_last && w_last;
                            cnt_next   = CNT_BITS'(nc_eff);
                        end
                        AXIS_ROW:
                        begin
                            first_next = row_pos_reg == '0;
                            emit_next  = r_last;
                            fl_next    = c_last && w_last;
                            cnt_next   = CNT_BITS'(nr_eff);
                        end
                        AXIS_COL:
                        begin
                            first_next = col_pos_reg == '0;
                            emit_next  = w_last;
                            fl_next    = c_last && r_last;
                            cnt_next   = CNT_BITS'(nw_eff);
                        end
                        default:
                        begin
                            first_next = (chan_pos_reg == '0) && (row_pos_reg == '0)
                                         && (col_pos_reg == '0);
                            emit_next  = c_last && r_last && w_last;
                            fl_next    = 1'b1;
                            cnt_next   = CNT_BITS'(nc_eff) * CNT_BITS'(nr_eff);
                        end
                    endcase
                    // advance position, column fastest
                    if (w_last)
                    begin
                        col_pos_next = '0;
                        if (r_last)
                        begin
                            row_pos_next  = '0;
                            chan_pos_next = c_last ? '0 : chan_pos_reg + POS_BITS'(1);
                        end
                        else
                        begin
                            row_pos_next = row_pos_reg + POS_BITS'(1);
                        end
                    end
                    else
                    begin
                        col_pos_next = col_pos_reg + POS_BITS'(1);
                    end
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                if (whole_reg)
                begin
                    total_sum_next = sum;
                end
                res_next = sum;
                neg_next = sum[ACC_BITS-1];
                if (!emit_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (mean_enable_reg)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = neg_reg ? ACC_BITS'(-div_quo) : div_quo;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_index_next = idx_reg;
                    out_last_next  = fl_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_mode_reg    <= AXIS_ALL;
            mean_enable_reg  <= 1'b0;
            num_channels_reg <= DIM_RESET;
            num_rows_reg     <= DIM_RESET;
            num_cols_reg     <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AXIS_MODE:    axis_mode_reg    <= cfg_wdata[1:0];
                CFG_MEAN_ENABLE:  mean_enable_reg  <= cfg_wdata[0];
                CFG_NUM_CHANNELS: num_channels_reg <= cfg_wdata;
                CFG_NUM_ROWS:     num_rows_reg     <= cfg_wdata;
                CFG_NUM_COLS:     num_cols_reg     <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            chan_pos_reg  <= '0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            total_sum_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_pos_reg  <= chan_pos_next;
            row_pos_reg   <= row_pos_next;
            col_pos_reg   <= col_pos_next;
            total_sum_reg <= total_sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        idx_reg       <= idx_next;
        cnt_reg       <= cnt_next;
        first_reg     <= first_next;
        emit_reg      <= emit_next;
        fl_reg        <= fl_next;
        whole_reg     <= whole_next;
        neg_reg       <= neg_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    // ports
    assign in_ch.ready         = state_reg == S_IDLE;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = RESULT_BITS'($signed(out_value_reg));
    assign out_ch.result_index = INDEX_BITS'(out_index_reg);
    assign out_ch.frame_last   = out_last_reg;

    // checks
    a_accept_to_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_ACC)
        else $error("accepted request did not enter accumulate step");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside divide wait");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(col_pos_reg) < MAX_DIM && int'(row_pos_reg) < MAX_DIM
        && int'(chan_pos_reg) < MAX_DIM)
        else $error("position counter beyond maximum dimension");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ch.ready) |=> state_reg == S_OUT)
        else $error("result left sequencer while output register was full");

endmodule

// ===== sim/tensor_axis_sum_mean_unit_tb.sv =====
module tensor_axis_sum_mean_unit_tb;
    import tasa_pkg::*;

    localparam int DRAIN_CYCLES = ACC_BITS_DEF + 24;
    localparam int RANDOM_ITEMS = 1200;

    // index with no register behind it
    localparam cfg_index_t CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [RESULT_BITS-1:0] value;
        logic [INDEX_BITS-1:0]  index;
        logic                   frame_end;
    } sum_result_t;

    logic clk;
    logic rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata;

    tasa_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_ch ();
    tasa_out_if out_ch ();

    tensor_axis_sum_mean_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the register file
    axis_mode_t axis_sel  = AXIS_ALL;
    logic       mean_on   = 1'b0;
    dim_cfg_t   chan_cfg  = DIM_RESET;
    dim_cfg_t   row_cfg   = DIM_RESET;
    dim_cfg_t   col_cfg   = DIM_RESET;

    // shadow copy of the datapath state
    logic [ACC_BITS_DEF-1:0] partial_sums [MAX_DIM_DEF*MAX_DIM_DEF];
    logic [ACC_BITS_DEF-1:0] grand_sum = '0;
    logic [5:0] chan_pos = '0;
    logic [5:0] row_pos  = '0;
    logic [5:0] col_pos  = '0;

    sum_result_t pending_sums [$];
    int          mismatch_count = 0;
    logic        src_pace  = 1'b0;
    logic        sink_pace = 1'b0;
    sum_result_t seen_want;

    // clock
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #50_000_000;
        $display("tensor_axis_sum_mean_unit_tb: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic logic [6:0] eff_dim(input dim_cfg_t v);
        if (v == '0)
            return 7'd1;
        if (v > 7'(MAX_DIM_DEF))
            return 7'(MAX_DIM_DEF);
        return v;
    endfunction

    // divide magnitude, restore sign
    function automatic logic [ACC_BITS_DEF-1:0] trunc_mean(input logic [ACC_BITS_DEF-1:0] s,
                                                           input logic [ACC_BITS_DEF-1:0] cnt);
        logic [ACC_BITS_DEF-1:0] mag;
        logic [ACC_BITS_DEF-1:0] q;
        mag = s[ACC_BITS_DEF-1] ? (~s + 1'b1) : s;
        q   = mag / cnt;
        return s[ACC_BITS_DEF-1] ? (~q + 1'b1) : q;
    endfunction

    function automatic int frame_len();
        return int'(eff_dim(chan_cfg)) * int'(eff_dim(row_cfg)) * int'(eff_dim(col_cfg));
    endfunction

    // fold one accepted sample into the shadow state, queue any finished sum
    task automatic reduce_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x);
        logic [6:0] nc;
        logic [6:0] nr;
        logic [6:0] nw;
        logic c_last;
        logic r_last;
        logic w_last;
        logic first;
        logic emit;
        logic fl;
        logic [ACC_BITS_DEF-1:0] xv;
        logic [ACC_BITS_DEF-1:0] s;
        logic [ACC_BITS_DEF-1:0] cnt;
        int unsigned flat;
        logic [INDEX_BITS-1:0] idx;
        sum_result_t res;
        nc = eff_dim(chan_cfg);
        nr = eff_dim(row_cfg);
        nw = eff_dim(col_cfg);
        c_last = chan_pos >= nc - 7'd1;
        r_last = row_pos >= nr - 7'd1;
        w_last = col_pos >= nw - 7'd1;
        xv = {{(ACC_BITS_DEF-SAMPLE_BITS_DEF){x[SAMPLE_BITS_DEF-1]}}, x};

        if (axis_sel == AXIS_ALL)
        begin
            first = (chan_pos == '0) && (row_pos == '0) && (col_pos == '0);
            grand_sum = first ? xv : grand_sum + xv;
            if (c_last && r_last && w_last)
            begin
                cnt = 40'(nc) * 40'(nr) * 40'(nw);
                res.value     = mean_on ? trunc_mean(grand_sum, cnt) : grand_sum;
                res.index     = '0;
                res.frame_end = 1'b1;
                pending_sums.push_back(res);
            end
        end
        else
        begin
            case (axis_sel)
                AXIS_CHAN:
                begin
                    flat  = row_pos * nw + col_pos;
                    first = chan_pos == '0;
                    emit  = c_last;
                    fl    = r_last && w_last;
                    cnt   = 40'(nc);
                end
                AXIS_ROW:
                begin
                    flat  = chan_pos * nw + col_pos;
                    first = row_pos == '0;
                    emit  = r_last;
                    fl    = c_last && w_last;
                    cnt   = 40'(nr);
                end
                default:
                begin
                    flat  = chan_pos * nr + row_pos;
                    first = col_pos == '0;
                    emit  = w_last;
                    fl    = c_last && r_last;
                    cnt   = 40'(nw);
                end
            endcase
            idx = flat[INDEX_BITS-1:0];
            s = first ? xv : partial_sums[idx] + xv;
            partial_sums[idx] = s;
            if (emit)
            begin
                res.value     = mean_on ? trunc_mean(s, cnt) : s;
                res.index     = idx;
                res.frame_end = fl;
                pending_sums.push_back(res);
            end
        end

        // advance position, column fastest
        if (w_last)
        begin
            col_pos = '0;
            if (r_last)
            begin
                row_pos  = '0;
                chan_pos = c_last ? 6'd0 : chan_pos + 6'd1;
            end
            else
                row_pos = row_pos + 6'd1;
        end
        else
            col_pos = col_pos + 6'd1;
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [SAMPLE_BITS_DEF-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'sh7FFF;
        else if (r < 20)
            return 16'sh8000;
        else if (r < 35)
            return 16'($urandom_range(0, 8) - 4);
        return 16'($urandom);
    endfunction

    // one request on the input channel; returns at the accepting edge
    task automatic send_sample(input logic signed [SAMPLE_BITS_DEF-1:0] x);
        int gap;
        gap = (src_pace && $urandom_range(0, 99) < 35) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= x;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        reduce_sample(x);
    endtask

    task automatic send_frames(input int n);
        repeat (n * frame_len())
            send_sample(pick_sample());
    endtask

    // stop sending, wait for every queued sum, then let the divider settle
    task automatic settle_idle();
        in_ch.valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_AXIS_MODE:    axis_sel = val[1:0];
            CFG_MEAN_ENABLE:  mean_on  = val[0];
            CFG_NUM_CHANNELS: chan_cfg = val;
            CFG_NUM_ROWS:     row_cfg  = val;
            CFG_NUM_COLS:     col_cfg  = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // unused upper data bits carry junk on the narrow registers
    task automatic apply_shape(input axis_mode_t mode, input logic mean,
                               input dim_cfg_t nc, input dim_cfg_t nr, input dim_cfg_t nw);
        logic [4:0] junk_a;
        logic [5:0] junk_m;
        junk_a = 5'($urandom);
        junk_m = 6'($urandom);
        program_reg(CFG_AXIS_MODE, {junk_a, mode});
        program_reg(CFG_MEAN_ENABLE, {junk_m, mean});
        program_reg(CFG_NUM_CHANNELS, nc);
        program_reg(CFG_NUM_ROWS, nr);
        program_reg(CFG_NUM_COLS, nw);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_sums.size() == 0)
                report_mismatch($sformatf("unexpected result value %h index %0d",
                                          out_ch.result_value, out_ch.result_index));
            else
            begin
                seen_want = pending_sums.pop_front();
                if (out_ch.result_value !== seen_want.value)
                    report_mismatch($sformatf("index %0d value %h, wanted %h",
                                              seen_want.index, out_ch.result_value,
                                              seen_want.value));
                if (out_ch.result_index !== seen_want.index)
                    report_mismatch($sformatf("result index %0d, wanted %0d",
                                              out_ch.result_index, seen_want.index));
                if (out_ch.frame_last !== seen_want.frame_end)
                    report_mismatch($sformatf("index %0d frame_last %b, wanted %b",
                                              seen_want.index, out_ch.frame_last,
                                              seen_want.frame_end));
            end
        end
    end

    // receiver with random stalls
    initial
    begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall == 0 && sink_pace && $urandom_range(0, 99) < 25)
                stall = idle_len();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                stall--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // reset values, then a partial frame that a dimension shrink closes early
    task automatic test_reset_shape();
        src_pace  = 1'b1;
        sink_pace = 1'b1;
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(-16'sd3);
        settle_idle();
        program_reg(CFG_NUM_CHANNELS, 7'd1);
        program_reg(CFG_NUM_ROWS, 7'd1);
        program_reg(CFG_NUM_COLS, 7'd1);
        // column past its dimension counts as last
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        settle_idle();
    endtask

    // whole-tensor sums and truncated means
    task automatic test_whole_tensor();
        src_pace  = 1'b0;
        sink_pace = 1'b0;
        apply_shape(AXIS_ALL, 1'b0, 7'd2, 7'd1, 7'd2);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(-16'sd1);
        settle_idle();
        apply_shape(AXIS_ALL, 1'b1, 7'd1, 7'd1, 7'd3);
        // negative means truncate toward zero
        send_sample(-16'sd1);
        send_sample(-16'sd1);
        send_sample(16'sd0);
        send_sample(-16'sd5);
        send_sample(-16'sd5);
        send_sample(-16'sd1);
        send_sample(16'sd7);
        send_sample(16'sd7);
        send_sample(16'sd8);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        settle_idle();
    endtask

    // each reduction axis, sum then mean
    task automatic test_each_axis();
        axis_mode_t mode;
        src_pace  = 1'b1;
        sink_pace = 1'b1;
        for (int m = 1; m < 4; m++)
        begin
            mode = axis_mode_t'(m);
            apply_shape(mode, 1'b0, 7'd2, 7'd2, 7'd2);
            send_frames(1);
            settle_idle();
        end
        apply_shape(AXIS_CHAN, 1'b1, 7'd3, 7'd1, 7'd1);
        send_frames(1);
        settle_idle();
        apply_shape(AXIS_ROW, 1'b1, 7'd1, 7'd3, 7'd1);
        send_frames(1);
        settle_idle();
        apply_shape(AXIS_COL, 1'b1, 7'd1, 7'd1, 7'd3);
        send_frames(1);
        settle_idle();
    endtask

    // top output index and clamped dimensions, reached by an axis switch mid-frame
    task automatic test_index_corner();
        src_pace  = 1'b1;
        sink_pace = 1'b1;
        apply_shape(AXIS_ALL, 1'b0, 7'd64, 7'd0, 7'd0);
        program_reg(CFG_UNUSED, 7'($urandom));
        repeat (63) send_sample(pick_sample());
        settle_idle();
        // one column per row, so every entry is written before it is read
        program_reg(CFG_AXIS_MODE, {5'd0, AXIS_COL});
        program_reg(CFG_NUM_ROWS, 7'd127);
        repeat (64) send_sample(pick_sample());
        settle_idle();
    endtask

    function automatic dim_cfg_t pick_small_dim();
        if ($urandom_range(0, 9) == 0)
            return 7'd0;
        return 7'($urandom_range(1, 4));
    endfunction

    // random shapes and modes, whole frames, occasional mean toggle mid-frame
    task automatic test_random_frames();
        int sent;
        int n;
        int which;
        dim_cfg_t shape [3];
        axis_mode_t mode;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            for (int k = 0; k < 3; k++)
                shape[k] = pick_small_dim();
            if ($urandom_range(0, 9) == 0)
            begin
                which = $urandom_range(0, 2);
                for (int k = 0; k < 3; k++)
                    if (eff_dim(shape[k]) > 7'd2)
                        shape[k] = 7'($urandom_range(1, 2));
                shape[which] = 7'($urandom_range(33, 127));
            end
            mode = axis_mode_t'($urandom_range(0, 3));
            apply_shape(mode, 1'($urandom), shape[0], shape[1], shape[2]);
            src_pace  = ($urandom_range(0, 4) != 0);
            sink_pace = ($urandom_range(0, 4) != 0);
            n = $urandom_range(1, 3) * frame_len();
            for (int k = 0; k < n; k++)
            begin
                send_sample(pick_sample());
                sent++;
                if ($urandom_range(0, 199) == 0)
                begin
                    settle_idle();
                    if ($urandom_range(0, 1) == 1)
                        program_reg(CFG_MEAN_ENABLE, {6'($urandom), ~mean_on});
                end
            end
            settle_idle();
        end
    endtask

    initial
    begin
        in_ch.valid        <= 1'b0;
        in_ch.sample_value <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_AXIS_MODE;
        cfg_wdata          <= '0;
        rst_n              <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_shape();
        test_whole_tensor();
        test_each_axis();
        test_index_corner();
        test_random_frames();
        settle_idle();

        if (mismatch_count == 0 && pending_sums.size() == 0)
            $display("tensor_axis_sum_mean_unit_tb: PASS");
        else
            $display("tensor_axis_sum_mean_unit_tb: FAIL");
        $finish;
    end

endmodule
